[hdl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Each macro expects clk and rst_n in scope; active-low synchronous reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GAONR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GAONR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gaonr_pkg.sv]
// Shared types and constants for the adjacency-matrix rewire block.
// No dependencies.
package gaonr_pkg;

  localparam int NODES_DEF = 64;
  localparam int ROW_W     = 64;
  localparam int NODE_W    = 6;
  localparam int OP_W      = 2;
  localparam int DEG_W     = 6;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [DEG_W-1:0]  deg_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_REWIRE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t   op;
    node_t node_a;
    node_t node_b;
    logic  act;
  } upd_ctl_t;

  typedef struct packed {
    logic  rd_en;
    node_t rd_addr;
    logic  wr_en;
    node_t wr_addr;
  } mem_req_t;

endpackage

[hdl/gaonr_ifs.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on gaonr_pkg.
interface gaonr_in_if;
  import gaonr_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, output op, output node_a, output node_b, input ready);
  modport sink   (input valid, input op, input node_a, input node_b, output ready);
endinterface

interface gaonr_out_if;
  import gaonr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_bits;
  logic [DEG_W-1:0] degree_a;
  logic [DEG_W-1:0] degree_b;

  modport source (output valid, output row_bits, output degree_a, output degree_b,
                  input ready);
  modport sink   (input valid, input row_bits, input degree_a, input degree_b,
                  output ready);
endinterface

[hdl/gaonr_row_mem.sv]
// Adjacency row memory: one write, one registered read per cycle.
// Per-row valid bits make unwritten rows read as zero. Depends on gaonr_pkg.
module gaonr_row_mem #(
  parameter int NODES = gaonr_pkg::NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gaonr_pkg::mem_req_t req,
  input  gaonr_pkg::row_t     wr_data,
  output gaonr_pkg::row_t     rd_data
);
  import gaonr_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  row_t             mem [NODES];
  logic [NODES-1:0] vld_r;
  row_t             rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      rd_vld_r <= req.rd_en & vld_r[req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[hdl/gaonr_row_unit.sv]
// Shared row update unit: applies add, remove or rewire to one stored row.
// Depends on gaonr_pkg.
module gaonr_row_unit (
  input  gaonr_pkg::upd_ctl_t ctl,
  input  gaonr_pkg::node_t    row_x,
  input  gaonr_pkg::row_t     row_in,
  input  gaonr_pkg::row_t     row_a,
  input  gaonr_pkg::row_t     row_b,
  output gaonr_pkg::row_t     row_out
);
  import gaonr_pkg::*;

  row_t bit_a;
  row_t bit_b;
  row_t a_clean;
  row_t b_clean;
  row_t only_a;
  logic is_a;
  logic is_b;

  assign bit_a   = row_t'(1) << ctl.node_a;
  assign bit_b   = row_t'(1) << ctl.node_b;
  assign a_clean = row_a & ~bit_b;
  assign b_clean = row_b & ~bit_a;
  assign only_a  = a_clean & ~b_clean;
  assign is_a    = (row_x == ctl.node_a);
  assign is_b    = (row_x == ctl.node_b);

  always_comb begin
    row_out = row_in;
    if (ctl.act) begin
      case (ctl.op)
        OP_ADD: begin
          if (is_a) row_out = row_in | bit_b;
          else if (is_b) row_out = row_in | bit_a;
        end
        OP_REMOVE: begin
          if (is_a) row_out = row_in & ~bit_b;
          else if (is_b) row_out = row_in & ~bit_a;
        end
        OP_REWIRE: begin
          // a keeps the intersection, b takes the union; a-only nodes move to b
          if (is_a) row_out = (a_clean & b_clean) | bit_b;
          else if (is_b) row_out = a_clean | b_clean | bit_a;
          else if (only_a[row_x]) row_out = (row_in & ~bit_a) | bit_b;
        end
        default: row_out = row_in;
      endcase
    end
  end

endmodule

[hdl/graph_and_or_neighbour_rewire.sv]
// Adjacency-matrix graph with add, remove, and-or rewire and row read.
// From request accept to result valid: two row fetches, one walk over all NODES
// rows through the shared row unit, then one load into the output register.
// One request at a time: a new request is accepted only after the result is loaded.
// Reset: synchronous active low; graph empty via per-row valid bits, no sweep.
module graph_and_or_neighbour_rewire #(
  parameter int NODES = gaonr_pkg::NODES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  gaonr_in_if.sink    in_ch,
  gaonr_out_if.source out_ch
);
  import gaonr_pkg::*;

  localparam int                CW       = $clog2(NODES + 1);
  localparam logic [CW-1:0]     CNT_LAST = CW'(NODES);
  localparam logic [NODE_W:0]   NODE_LIM = (NODE_W + 1)'(NODES);

  state_t         state_r, state_nxt;
  op_t            op_r, op_nxt;
  node_t          a_r, a_nxt;
  node_t          b_r, b_nxt;
  logic           act_r, act_nxt;
  logic           pair_ok_r, pair_ok_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  row_t           row_a_r, row_a_nxt;
  row_t           row_b_r, row_b_nxt;
  row_t           acc_row_r, acc_row_nxt;
  deg_t           deg_a_r, deg_a_nxt;
  deg_t           deg_b_r, deg_b_nxt;
  logic           out_vld_r, out_vld_nxt;
  row_t           out_row_r, out_row_nxt;
  deg_t           out_deg_a_r, out_deg_a_nxt;
  deg_t           out_deg_b_r, out_deg_b_nxt;

  logic           in_acc;
  logic           in_a_ok;
  logic           in_b_ok;
  logic           walk_proc;
  logic           load_out;
  logic [CW-1:0]  proc_cnt;
  node_t          proc_x;
  mem_req_t       mem_req;
  upd_ctl_t       upd_ctl;
  row_t           rd_data;
  row_t           row_new;
  logic           new_bit_a;
  logic           new_bit_b;

  gaonr_row_mem #(.NODES(NODES)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .wr_data (row_new),
    .rd_data (rd_data)
  );

  gaonr_row_unit u_unit (
    .ctl     (upd_ctl),
    .row_x   (proc_x),
    .row_in  (rd_data),
    .row_a   (row_a_r),
    .row_b   (row_b_r),
    .row_out (row_new)
  );

  assign in_acc    = in_ch.valid & in_ch.ready;
  assign in_a_ok   = {1'b0, in_ch.node_a} < NODE_LIM;
  assign in_b_ok   = {1'b0, in_ch.node_b} < NODE_LIM;
  assign proc_cnt  = cnt_r - CW'(1);
  assign proc_x    = NODE_W'(proc_cnt);
  assign walk_proc = (state_r == ST_WALK) && (cnt_r != '0);
  assign load_out  = (state_r == ST_FINISH) && (!out_vld_r || out_ch.ready);
  assign new_bit_a = row_new[a_r];
  assign new_bit_b = row_new[b_r];

  assign upd_ctl.op     = op_r;
  assign upd_ctl.node_a = a_r;
  assign upd_ctl.node_b = b_r;
  assign upd_ctl.act    = act_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_ch.valid) state_nxt = ST_FETCH_A;
      ST_FETCH_A: state_nxt = ST_FETCH_B;
      ST_FETCH_B: state_nxt = ST_WALK;
      ST_WALK:    if (cnt_r == CNT_LAST) state_nxt = ST_FINISH;
      ST_FINISH:  if (!out_vld_r || out_ch.ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready     = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = a_r;
    mem_req.wr_en   = walk_proc & act_r;
    mem_req.wr_addr = proc_x;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_FETCH_A: begin
        mem_req.rd_en   = pair_ok_r;
        mem_req.rd_addr = a_r;
      end
      ST_FETCH_B: begin
        mem_req.rd_en   = pair_ok_r;
        mem_req.rd_addr = b_r;
      end
      ST_WALK: begin
        mem_req.rd_en   = (cnt_r != CNT_LAST);
        mem_req.rd_addr = NODE_W'(cnt_r);
      end
      default: in_ch.ready = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    act_nxt       = act_r;
    pair_ok_nxt   = pair_ok_r;
    cnt_nxt       = cnt_r;
    row_a_nxt     = row_a_r;
    row_b_nxt     = row_b_r;
    acc_row_nxt   = acc_row_r;
    deg_a_nxt     = deg_a_r;
    deg_b_nxt     = deg_b_r;
    out_row_nxt   = out_row_r;
    out_deg_a_nxt = out_deg_a_r;
    out_deg_b_nxt = out_deg_b_r;
    out_vld_nxt   = out_vld_r & ~out_ch.ready;

    if (in_acc) begin
      op_nxt      = op_t'(in_ch.op);
      a_nxt       = in_ch.node_a;
      b_nxt       = in_ch.node_b;
      pair_ok_nxt = in_a_ok & in_b_ok;
      act_nxt     = in_a_ok & in_b_ok & (in_ch.node_a != in_ch.node_b);
      cnt_nxt     = '0;
      acc_row_nxt = '0;
      deg_a_nxt   = '0;
      deg_b_nxt   = '0;
    end
    if (state_r == ST_FETCH_B) begin
      row_a_nxt = rd_data;
    end
    if (state_r == ST_WALK) begin
      if (cnt_r == '0) row_b_nxt = rd_data;
      if (cnt_r != CNT_LAST) cnt_nxt = cnt_r + CW'(1);
    end
    // symmetric matrix: bit x of row a equals bit a of row x
    if (walk_proc) begin
      acc_row_nxt = acc_row_r | (row_t'(new_bit_a) << proc_x);
      deg_a_nxt   = deg_a_r + deg_t'(new_bit_a);
      deg_b_nxt   = deg_b_r + deg_t'(new_bit_b);
    end
    if (load_out) begin
      out_vld_nxt   = 1'b1;
      out_row_nxt   = acc_row_r;
      out_deg_a_nxt = deg_a_r;
      out_deg_b_nxt = deg_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    act_r       <= act_nxt;
    pair_ok_r   <= pair_ok_nxt;
    cnt_r       <= cnt_nxt;
    row_a_r     <= row_a_nxt;
    row_b_r     <= row_b_nxt;
    acc_row_r   <= acc_row_nxt;
    deg_a_r     <= deg_a_nxt;
    deg_b_r     <= deg_b_nxt;
    out_row_r   <= out_row_nxt;
    out_deg_a_r <= out_deg_a_nxt;
    out_deg_b_r <= out_deg_b_nxt;
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.row_bits = out_row_r;
  assign out_ch.degree_a = out_deg_a_r;
  assign out_ch.degree_b = out_deg_b_r;

endmodule

[hdl/gaonr_checker.sv]
// Port-level assertions for graph_and_or_neighbour_rewire, bound to the top.
// Depends on gaonr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gaonr_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input gaonr_pkg::row_t         out_row_bits,
  input gaonr_pkg::deg_t         out_degree_a,
  input gaonr_pkg::deg_t         out_degree_b
);
  import gaonr_pkg::*;

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid & in_ready;
  assign out_stall = out_valid & ~out_ready;

  `GAONR_ASSERT_NXT(a_busy_after_req, in_acc, !in_ready, "ready high right after a request")
  `GAONR_ASSERT_NXT(a_no_early_result, in_acc && !out_stall, !out_valid, "result too early")
  `GAONR_ASSERT_IMP(a_degree_matches_row, out_valid, $countones(out_row_bits) == int'(out_degree_a), "degree_a disagrees with row_bits")
  `GAONR_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_row_bits) && $stable(out_degree_a) && $stable(out_degree_b), "stalled result changed")

endmodule

bind graph_and_or_neighbour_rewire gaonr_checker u_gaonr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_row_bits (out_ch.row_bits),
  .out_degree_a (out_ch.degree_a),
  .out_degree_b (out_ch.degree_b)
);
